// File: rtl/hcsf_pkg.sv
// Shared types, constants and the TTL to hop count conversion of the hop count filter.
package hcsf_pkg;

  localparam int ROWS_DEFAULT = 256;
  localparam int COLS_DEFAULT = 256;

  localparam int TTL_W  = 8;
  localparam int INDEX_W = 8;
  localparam int HOPS_W = 7;
  localparam int ENTRY_W = HOPS_W + 1;
  localparam int TOL_W  = 7;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2);

  // register index as seen on paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;

  typedef enum logic [1:0] {
    VERDICT_LEARNED = 2'd0,
    VERDICT_MATCH   = 2'd1,
    VERDICT_SPOOF   = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_EVAL
  } state_t;

  // hop count against the smallest usual initial TTL (64, 128 or 255) not below the TTL
  function automatic logic [HOPS_W-1:0] ttl_to_hops(input logic [TTL_W-1:0] ttl);
    logic [TTL_W-1:0] hops;
    begin
      if (ttl <= TTL_W'(64)) begin
        hops = TTL_W'(64) - ttl;
      end else if (ttl <= TTL_W'(128)) begin
        hops = TTL_W'(128) - ttl;
      end else begin
        hops = TTL_W'(255) - ttl;
      end
      ttl_to_hops = hops[HOPS_W-1:0];
    end
  endfunction

endpackage

// File: rtl/hop_count_spoof_filter.sv
// Hop count spoof filter: hop count table in one memory with read-modify-write.
//
// Usage: raise start with row_index, col_index, packet_ttl and probed_ttl while
// busy is low; the word is taken at that clock edge. Exactly one result word
// follows: done is high for one cycle with verdict, computed_hops and
// stored_hops. The receiver cannot stall; results are not held.
// done rises at the same edge at which busy falls, so the block takes a new
// word only after the result of the last one. The pace is set by
// the address stage (index wrap and row*COLS+col), the registered read of the
// table memory and the evaluate/write-back stage; each word goes through them
// one at a time, so a learn write is complete before the next read.
// Reset (rst, synchronous): tolerance returns to 2 and a clearing pass marks
// every table entry unlearned, one entry per cycle through all ROWS*COLS
// entries (65536 with the default size). busy stays high during the pass; APB
// writes to tolerance are taken during the pass too, pready is always high.
module hop_count_spoof_filter
  import hcsf_pkg::*;
#(
  parameter int ROWS = ROWS_DEFAULT,
  parameter int COLS = COLS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [INDEX_W-1:0]   row_index,
  input  logic [INDEX_W-1:0]   col_index,
  input  logic [TTL_W-1:0]     packet_ttl,
  input  logic [TTL_W-1:0]     probed_ttl,
  output logic                 done,
  output logic [1:0]           verdict,
  output logic [HOPS_W-1:0]    computed_hops,
  output logic [HOPS_W-1:0]    stored_hops,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int NIDX  = 1 << INDEX_W;

  // ---------------- configuration ----------------
  logic [TOL_W-1:0] tolerance;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_wr && paddr[2] == REG_TOLERANCE) begin
      tolerance <= pwdata[TOL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOLERANCE) begin
      prdata = APB_DW'(tolerance);
    end
  end

  // ---------------- index wrap tables ----------------
  logic [RW-1:0] row_wrap [NIDX];
  logic [CW-1:0] col_wrap [NIDX];

  for (genvar gi = 0; gi < NIDX; gi++) begin : g_wrap
    assign row_wrap[gi] = RW'(gi % ROWS);
    assign col_wrap[gi] = CW'(gi % COLS);
  end

  // ---------------- control ----------------
  state_t state, state_next;
  logic   mem_we;
  logic [AW-1:0] clr_addr;
  logic          clr_last;

  assign clr_last = (clr_addr == AW'(DEPTH - 1));

  // ---------------- datapath registers ----------------
  logic [INDEX_W-1:0] row_q, col_q;
  logic [TTL_W-1:0]   pttl_q, qttl_q;
  logic [AW-1:0]      addr;
  logic [HOPS_W-1:0]  comp_hops;
  logic [HOPS_W-1:0]  learn_hops;
  logic [ENTRY_W-1:0] rdata;

  logic [ENTRY_W-1:0] mem [DEPTH];

  logic               entry_valid;
  logic [HOPS_W-1:0]  entry_hops;
  logic [HOPS_W-1:0]  hop_diff;
  verdict_t           verdict_c;
  logic [HOPS_W-1:0]  stored_c;
  logic [AW:0]        addr_sum;

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    mem_we     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        mem_we     = ~entry_valid;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EVAL);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // input capture and address stage
  assign addr_sum = (AW+1)'(row_wrap[row_q]) * (AW+1)'(COLS) + (AW+1)'(col_wrap[col_q]);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      row_q  <= row_index;
      col_q  <= col_index;
      pttl_q <= packet_ttl;
      qttl_q <= probed_ttl;
    end
    if (state == ST_ADDR) begin
      addr       <= addr_sum[AW-1:0];
      comp_hops  <= ttl_to_hops(pttl_q);
      learn_hops <= ttl_to_hops(qttl_q);
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (state == ST_CLEAR) begin
        mem[clr_addr] <= '0;
      end else begin
        mem[addr] <= {1'b1, learn_hops};
      end
    end
    rdata <= mem[addr];
  end

  // evaluate
  assign entry_valid = rdata[ENTRY_W-1];
  assign entry_hops  = rdata[HOPS_W-1:0];
  assign hop_diff    = (entry_hops >= comp_hops) ? entry_hops - comp_hops
                                                 : comp_hops - entry_hops;

  always_comb begin
    if (!entry_valid) begin
      verdict_c = VERDICT_LEARNED;
      stored_c  = learn_hops;
    end else begin
      stored_c  = entry_hops;
      verdict_c = (hop_diff <= tolerance) ? VERDICT_MATCH : VERDICT_SPOOF;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      verdict       <= verdict_c;
      computed_hops <= comp_hops;
      stored_hops   <= stored_c;
    end
  end

endmodule

// File: test/tb_hop_count_spoof_filter.sv
// Self-checking testbench for hop_count_spoof_filter: predicts each verdict word and compares.
`timescale 1ns / 1ps

module tb_hop_count_spoof_filter;
  import hcsf_pkg::*;

  localparam int ROWS = ROWS_DEFAULT;
  localparam int COLS = COLS_DEFAULT;
  localparam int TOL_REG = 0;          // tolerance register
  localparam int NO_REG = 1;           // index past the register list
  localparam int QUIET_LIMIT = 200000; // covers the clearing pass after reset
  localparam int POOL = 16;
  localparam int NPHASE = 7;

  typedef struct packed {
    logic [INDEX_W-1:0] row;
    logic [INDEX_W-1:0] col;
    logic [TTL_W-1:0]   ttl;
    logic [TTL_W-1:0]   probed;
  } packet_t;

  typedef struct packed {
    verdict_t            verdict;
    logic [HOPS_W-1:0]   computed;
    logic [HOPS_W-1:0]   stored;
  } verdict_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [INDEX_W-1:0] row_index = '0;
  logic [INDEX_W-1:0] col_index = '0;
  logic [TTL_W-1:0] packet_ttl = '0;
  logic [TTL_W-1:0] probed_ttl = '0;
  logic done;
  logic [1:0] verdict;
  logic [HOPS_W-1:0] computed_hops;
  logic [HOPS_W-1:0] stored_hops;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  hop_count_spoof_filter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .row_index(row_index), .col_index(col_index),
    .packet_ttl(packet_ttl), .probed_ttl(probed_ttl),
    .done(done), .verdict(verdict), .computed_hops(computed_hops),
    .stored_hops(stored_hops),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // model state: bit 7 learned, bits 6..0 hop count
  logic [ENTRY_W-1:0] hop_mem [0:ROWS*COLS-1];
  logic [TOL_W-1:0] tol_model;

  packet_t packets_to_send[$];
  verdict_word_t pending_verdicts[$];
  int idle_pct = 0;
  int errors = 0;
  int n_sent = 0;
  int n_learned = 0;
  int n_match = 0;
  int n_spoof = 0;
  int quiet = 0;

  logic [INDEX_W-1:0] pool_row [POOL];
  logic [INDEX_W-1:0] pool_col [POOL];
  logic [TTL_W-1:0] pool_ttl [POOL];

  function automatic logic [HOPS_W-1:0] hops_of(input logic [TTL_W-1:0] ttl);
    int t;
    t = int'(ttl);
    if (t <= 64) return HOPS_W'(64 - t);
    if (t <= 128) return HOPS_W'(128 - t);
    return HOPS_W'(255 - t);
  endfunction

  // learn or compare against the addressed entry, updating the table copy
  function automatic verdict_word_t judge_packet(input packet_t p);
    verdict_word_t w;
    int addr;
    int diff;
    addr = (int'(p.row) % ROWS) * COLS + (int'(p.col) % COLS);
    w.computed = hops_of(p.ttl);
    if (!hop_mem[addr][ENTRY_W-1]) begin
      w.stored = hops_of(p.probed);
      hop_mem[addr] = {1'b1, w.stored};
      w.verdict = VERDICT_LEARNED;
    end else begin
      w.stored = hop_mem[addr][HOPS_W-1:0];
      diff = int'(w.stored) - int'(w.computed);
      if (diff < 0) diff = -diff;
      w.verdict = (diff <= int'(tol_model)) ? VERDICT_MATCH : VERDICT_SPOOF;
    end
    return w;
  endfunction

  // mostly revisits a small set of sources with TTLs near their learned one
  function automatic packet_t make_packet();
    packet_t p;
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 25) begin
      p = packet_t'($urandom);
    end else begin
      k = $urandom_range(POOL - 1);
      if ($urandom_range(19) == 0) begin
        pool_row[k] = INDEX_W'($urandom);
        pool_col[k] = INDEX_W'($urandom);
        pool_ttl[k] = TTL_W'($urandom);
      end
      p.row = pool_row[k];
      p.col = pool_col[k];
      p.probed = pool_ttl[k] + TTL_W'($urandom_range(4)) - TTL_W'(2);
      if (r < 85) p.ttl = pool_ttl[k] + TTL_W'($urandom_range(16)) - TTL_W'(8);
      else p.ttl = TTL_W'($urandom);
    end
    return p;
  endfunction

  function automatic packet_t pkt(input int r, input int c, input int t, input int pr);
    packet_t p;
    p.row = INDEX_W'(r);
    p.col = INDEX_W'(c);
    p.ttl = TTL_W'(t);
    p.probed = TTL_W'(pr);
    return p;
  endfunction

  task automatic reg_write(input int idx, input int val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx * 4);
    pwdata <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == TOL_REG) tol_model = TOL_W'(val);
  endtask

  task automatic tolerance_read_check();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_AW'(TOL_REG * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_DW'(tol_model)) begin
      $error("tolerance readback: expected %0d, actual %0d", tol_model, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (packets_to_send.size() != 0 || start || pending_verdicts.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // driver: one word in flight on the ports until busy is low
  always @(posedge clk) begin : drive
    packet_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_verdicts.push_back(judge_packet({row_index, col_index, packet_ttl, probed_ttl}));
        n_sent++;
      end
      if (!start || !busy) begin
        if (packets_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = packets_to_send.pop_front();
          start <= 1'b1;
          row_index <= nxt.row;
          col_index <= nxt.col;
          packet_ttl <= nxt.ttl;
          probed_ttl <= nxt.probed;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done word against the oldest prediction
  always @(posedge clk) begin : observe
    verdict_word_t want;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $error("result word with no prediction pending");
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict !== want.verdict) begin
          $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
          errors++;
        end
        if (computed_hops !== want.computed) begin
          $error("computed_hops: expected %0d, actual %0d", want.computed, computed_hops);
          errors++;
        end
        if (stored_hops !== want.stored) begin
          $error("stored_hops: expected %0d, actual %0d", want.stored, stored_hops);
          errors++;
        end
        case (want.verdict)
          VERDICT_LEARNED: n_learned++;
          VERDICT_MATCH:   n_match++;
          default:         n_spoof++;
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("hop_count_spoof_filter: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int ph_idle [NPHASE];
    int ph;
    ph_idle = '{0, 66, 15, 0, 66, 15, 0};
    for (int i = 0; i < ROWS * COLS; i++) hop_mem[i] = '0;
    tol_model = TOL_RESET;
    for (int k = 0; k < POOL; k++) begin
      pool_row[k] = INDEX_W'($urandom);
      pool_col[k] = INDEX_W'($urandom);
      pool_ttl[k] = TTL_W'($urandom);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    tolerance_read_check();

    // directed: TTL range edges, learn / match / spoof around tolerance 2
    packets_to_send.push_back(pkt(0, 0, 0, 0));
    packets_to_send.push_back(pkt(0, 0, 0, 99));
    packets_to_send.push_back(pkt(0, 0, 62, 0));
    packets_to_send.push_back(pkt(0, 0, 2, 0));
    packets_to_send.push_back(pkt(0, 0, 3, 0));
    packets_to_send.push_back(pkt(255, 255, 255, 129));
    packets_to_send.push_back(pkt(255, 255, 129, 0));
    packets_to_send.push_back(pkt(255, 255, 128, 0));
    packets_to_send.push_back(pkt(255, 0, 64, 255));
    packets_to_send.push_back(pkt(255, 0, 128, 0));
    packets_to_send.push_back(pkt(255, 0, 65, 0));
    packets_to_send.push_back(pkt(0, 255, 128, 128));
    packets_to_send.push_back(pkt(0, 255, 1, 0));
    packets_to_send.push_back(pkt(0, 255, 126, 0));
    packets_to_send.push_back(pkt(0, 255, 125, 0));
    packets_to_send.push_back(pkt(170, 85, 85, 170));
    packets_to_send.push_back(pkt(85, 170, 170, 85));
    packets_to_send.push_back(pkt(170, 85, 170, 0));
    packets_to_send.push_back(pkt(85, 170, 192, 64));

    for (ph = 0; ph < NPHASE; ph++) begin
      if (ph != 0) begin
        drain();
        case (ph)
          1: reg_write(TOL_REG, 0);
          2: reg_write(NO_REG, 127);   // must not touch tolerance
          3: reg_write(TOL_REG, 127);
          4: reg_write(TOL_REG, $urandom_range(127));
          5: reg_write(TOL_REG, 1);
          default: reg_write(TOL_REG, $urandom_range(12, 3));
        endcase
        tolerance_read_check();
      end
      idle_pct <= ph_idle[ph];
      for (int i = 0; i < 130; i++) packets_to_send.push_back(make_packet());
    end
    drain();

    $display("sent %0d packets over %0d tolerance/idle phases", n_sent, NPHASE);
    $display("verdicts: %0d learned, %0d match, %0d spoof", n_learned, n_match, n_spoof);
    if (errors == 0) begin
      $display("hop_count_spoof_filter: match");
    end else begin
      $display("hop_count_spoof_filter: mismatch");
    end
    $finish;
  end

endmodule
